[design/art_pkg.sv]
// Package for the address record table: sizes, transaction types and the
// command/status bundles shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package art_pkg;

    localparam int TABLE_DEPTH = 16;
    // index/count width: holds 0..TABLE_DEPTH
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    // entry address width
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOT_W = 4;
    localparam int CLR_W  = 5;
    localparam int USED_W = 5;
    localparam int ENTRY_W = 64;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] iface;
        logic [7:0]  tag;
        logic [31:0] ip_address;
        logic [7:0]  mask_len;
    } t_in_item;

    typedef struct packed {
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic [CLR_W-1:0]  cleared;
        logic [USED_W-1:0] used_count;
    } t_out_item;

    typedef struct packed {
        logic load;         // latch transaction, restart scan
        logic step;         // advance scan index
        logic rec_write;    // write record at scan index
        logic append;       // raise high-water count
        logic flush_clear;  // invalidate entry at scan index
        logic emit;         // capture result
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic at_end;       // scan index reached high-water count
        logic empty;        // entry at scan index is all zero
        logic hit;          // entry matches flush filters
        logic full;         // high-water count equals depth
    } t_stat;

endpackage

`default_nettype wire

[design/address_record_table_unit.sv]
// Address record table, first-fit slot allocation with high-water count.
// A record scans from index 0 up to the first hole or the count, a flush scans
// up to the count; o_valid is registered once the scan ends. Results cannot be held off.
// busy drops with o_valid, so a new item is taken only after the last result;
// the scan reads one entry per cycle.
// Synchronous active-low reset clears the table and the count at once.
`default_nettype none

module address_record_table_unit import art_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_item  i_item,
    output logic           busy,
    output logic           o_valid,
    output t_out_item      o_result
);

    t_cmd  cmd;
    t_stat stat;

    art_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    art_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transaction did not start a scan");

    a_no_mixed_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.stored && (o_result.cleared != '0)))
        else $error("result reports both a store and a flush count");

    a_write_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rec_write || cmd.flush_clear) |-> busy)
        else $error("table modified outside a scan");
`endif

endmodule

`default_nettype wire

[design/art_dp.sv]
// Datapath of the address record table: entry storage, valid bits,
// scan index, high-water count and result register. Uses art_pkg.
`default_nettype none

module art_dp import art_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat,
    output t_out_item      o_result
);

    t_in_item                r_in;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_hw;
    logic [CNT_W-1:0]        r_cleared;
    logic [TABLE_DEPTH-1:0]  r_valid;
    logic [ENTRY_W-1:0]      r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]      r_entry;
    t_out_item               r_res;

    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   n_idx;
    logic [ADDR_W-1:0]  n_addr;
    logic [ENTRY_W-1:0] new_word;
    logic [15:0]        e_iface;
    logic [7:0]         e_tag;
    logic [CNT_W-1:0]   n_hw;

    assign addr     = r_idx[ADDR_W-1:0];
    assign n_idx    = i_cmd.load ? '0 : (i_cmd.step ? r_idx + CNT_W'(1) : r_idx);
    assign n_addr   = n_idx[ADDR_W-1:0];
    assign e_iface  = r_entry[15:0];
    assign e_tag    = r_entry[23:16];
    assign new_word = {r_in.mask_len, r_in.ip_address, r_in.tag, r_in.iface};
    assign n_hw     = i_cmd.append ? r_hw + CNT_W'(1) : r_hw;

    assign o_stat.mode   = r_in.mode;
    assign o_stat.at_end = (r_idx == r_hw);
    assign o_stat.empty  = (r_entry == '0);
    assign o_stat.hit    = ((r_in.iface == 16'd0) || (e_iface == r_in.iface)) &&
                           ((r_in.tag == 8'd0) || (e_tag == r_in.tag));
    assign o_stat.full   = (r_hw == CNT_W'(TABLE_DEPTH));
    assign o_result      = r_res;

    // r_entry follows the scan index: the entry at the next index is fetched
    // at every edge. An entry never written since reset or flushed reads as
    // zero. A record write targets the entry fetched at the same edge, which gets the old value.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_write) begin
            r_mem[addr] <= new_word;
        end
        r_entry <= r_valid[n_addr] ? r_mem[n_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.emit) begin
            r_res.stored     <= i_cmd.rec_write;
            r_res.slot       <= i_cmd.rec_write ? SLOT_W'(r_idx) : '0;
            r_res.cleared    <= (r_in.mode == MODE_FLUSH) ? CLR_W'(r_cleared) : '0;
            r_res.used_count <= USED_W'(n_hw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_hw      <= '0;
            r_cleared <= '0;
            r_valid   <= '0;
        end else begin
            r_hw  <= n_hw;
            r_idx <= n_idx;
            if (i_cmd.load) begin
                r_cleared <= '0;
            end
            if (i_cmd.rec_write) begin
                r_valid[addr] <= 1'b1;
            end else if (i_cmd.flush_clear) begin
                r_valid[addr] <= 1'b0;
                if (r_entry != '0) begin
                    r_cleared <= r_cleared + CNT_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/art_ctrl.sv]
// Controller of the address record table: scan sequencer that drives the
// datapath commands and the result strobe. Uses art_pkg.
`default_nettype none

module art_ctrl import art_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       busy,
    output logic       o_valid
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.mode == MODE_RECORD) begin
                    if (i_stat.at_end) begin
                        // no hole below the count: append unless full
                        o_cmd.rec_write = !i_stat.full;
                        o_cmd.append    = !i_stat.full;
                        o_cmd.emit      = 1'b1;
                        n_valid         = 1'b1;
                        n_state         = S_IDLE;
                    end else if (i_stat.empty) begin
                        o_cmd.rec_write = 1'b1;
                        o_cmd.emit      = 1'b1;
                        n_valid         = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    if (i_stat.at_end) begin
                        o_cmd.emit = 1'b1;
                        n_valid    = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.flush_clear = i_stat.hit;
                        o_cmd.step        = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

[sim/record_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the address record table: tracks accepted commands, predicts
// each result from its own copy of the table and compares field by field.
// Depends on art_pkg.
module record_table_checker import art_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_item  i_item,
    input  wire logic      i_valid,
    input  wire t_out_item i_result,
    output int             o_pending,
    output int             o_errors
);

    logic [ENTRY_W-1:0] rec_mem [TABLE_DEPTH];
    int unsigned        high_water;
    t_out_item          due_results [$];
    int                 err_cnt = 0;

    // One record or flush applied to the shadow table.
    task automatic table_update(input t_in_item it, output t_out_item res);
        int unsigned lim;
        int unsigned pick;
        int unsigned clr;
        bit          found;
        logic [15:0] e_if;
        logic [7:0]  e_tg;
        res   = '0;
        found = 1'b0;
        clr   = 0;
        lim   = (high_water > TABLE_DEPTH) ? TABLE_DEPTH : high_water;
        if (it.mode == MODE_RECORD) begin
            pick = lim;
            for (int i = 0; i < lim; i++) begin
                if (!found && rec_mem[i] == '0) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (!found && lim < TABLE_DEPTH) begin
                pick       = lim;
                high_water = lim + 1;
                found      = 1'b1;
            end
            if (found) begin
                rec_mem[pick] = {it.mask_len, it.ip_address, it.tag, it.iface};
                res.stored    = 1'b1;
                res.slot      = pick[SLOT_W-1:0];
            end
        end else begin
            for (int i = 0; i < lim; i++) begin
                e_if = rec_mem[i][15:0];
                e_tg = rec_mem[i][23:16];
                if ((it.iface == '0 || e_if == it.iface) &&
                    (it.tag == '0 || e_tg == it.tag)) begin
                    // already-empty entries get rezeroed but do not count
                    if (rec_mem[i] != '0)
                        clr++;
                    rec_mem[i] = '0;
                end
            end
            res.cleared = clr[CLR_W-1:0];
        end
        res.used_count = high_water[USED_W-1:0];
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                rec_mem[i] = '0;
            high_water = 0;
            due_results.delete();
        end else begin
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    $error("result %h with no pending transaction", i_result);
                    err_cnt++;
                end else begin
                    want = due_results.pop_front();
                    check_field("stored", want.stored, i_result.stored);
                    check_field("slot", want.slot, i_result.slot);
                    check_field("cleared", want.cleared, i_result.cleared);
                    check_field("used_count", want.used_count, i_result.used_count);
                end
            end
            if (i_start && !i_busy) begin
                table_update(i_item, want);
                due_results.push_back(want);
            end
        end
        o_pending <= due_results.size();
        o_errors  <= err_cnt;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench top for address_record_table_unit: reset, directed and random
// record/flush stimulus with sender idling; verdict from record_table_checker.
// Depends on art_pkg, address_record_table_unit and record_table_checker.
module tb import art_pkg::*; ();

    localparam int          RUN_ITEMS   = 1750;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_in_item    i_item;
    logic        busy;
    logic        o_valid;
    t_out_item   o_result;
    int          pending;
    int          errors;
    int unsigned cycles = 0;
    int          idle_pct [4] = '{0, 69, 6, 0};

    address_record_table_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    record_table_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .o_pending (pending),
        .o_errors  (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold the command until the block takes it.
    task automatic issue(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending until every outstanding result is back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic t_in_item mk_cmd(input logic md, input logic [15:0] ifc,
                                        input logic [7:0] tg, input logic [31:0] ip,
                                        input logic [7:0] mk);
        t_in_item it;
        it.mode       = md;
        it.iface      = ifc;
        it.tag        = tg;
        it.ip_address = ip;
        it.mask_len   = mk;
        return it;
    endfunction

    // Small iface/tag pools so flushes actually hit recorded entries.
    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned r;
        it.mode = ($urandom_range(0, 3) == 0) ? MODE_FLUSH : MODE_RECORD;
        r = $urandom_range(0, 9);
        it.iface = (r < 2) ? 16'h0 : (r < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        r = $urandom_range(0, 9);
        it.tag = (r < 2) ? 8'h0 : (r < 8) ? 8'($urandom_range(1, 3)) : 8'($urandom);
        it.ip_address = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
        it.mask_len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 32));
        if (it.mode == MODE_RECORD && $urandom_range(0, 29) == 0)
            it = mk_cmd(MODE_RECORD, 16'h0, 8'h0, 32'h0, 8'h0);
        return it;
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero record reads as empty, so the next record reuses slot 0
        issue(mk_cmd(MODE_RECORD, 16'h0, 8'h0, 32'h0, 8'h0));
        issue(mk_cmd(MODE_RECORD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        for (int k = 1; k < TABLE_DEPTH; k++)
            issue(mk_cmd(MODE_RECORD, 16'(k % 4 + 1), 8'(k % 3 + 1), $urandom, 8'(k)));
        // table full: dropped
        issue(mk_cmd(MODE_RECORD, 16'h5, 8'h5, $urandom, 8'h18));
        issue(mk_cmd(MODE_FLUSH, 16'h2, 8'h3, $urandom, 8'($urandom)));
        issue(mk_cmd(MODE_FLUSH, 16'h0, 8'h1, $urandom, 8'($urandom)));
        issue(mk_cmd(MODE_FLUSH, 16'h1, 8'h0, $urandom, 8'($urandom)));
        issue(mk_cmd(MODE_RECORD, 16'h7, 8'h9, 32'h0A00_0001, 8'h10));
        // wildcard flush clears everything; repeat rezeroes empties uncounted
        issue(mk_cmd(MODE_FLUSH, 16'h0, 8'h0, 32'hFFFF_FFFF, 8'hFF));
        issue(mk_cmd(MODE_FLUSH, 16'h0, 8'h0, 32'h0, 8'h0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < RUN_ITEMS / 4; n++) begin
                if ($urandom_range(0, 99) < idle_pct[ph])
                    hold_off($urandom_range(1, 24));
                else if ($urandom_range(0, 199) == 0)
                    drain();
                issue(rand_item());
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
